// ===== hw/rtl/mpwc_pkg.sv =====
`default_nettype none
package mpwc_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int TIMER_WIDTH_DEF = 16;
	localparam int MAX_CHANNELS    = 8;
	localparam int CHAN_W          = 3;
	localparam int WIDTH_W         = 16;
	localparam int PERIOD_W        = 16;
	localparam int MASK_W          = 8;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MASK = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMER_PERIOD = 1'b1;

	localparam logic [MASK_W-1:0]   CHANNEL_MASK_RST = 8'hFF;
	localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RST = 16'hFFFF;

	typedef struct packed {
		logic               pend;
		logic [WIDTH_W-1:0] width;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mpwc_lane.sv =====
`default_nettype none
module mpwc_lane #(
	parameter int TIMER_WIDTH = mpwc_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic                   flag,
	input  wire logic [TIMER_WIDTH-1:0] now,
	input  wire logic [TIMER_WIDTH-1:0] period,
	input  wire logic                   take,
	output mpwc_pkg::lane_res_t         res
);
	import mpwc_pkg::*;

	logic [TIMER_WIDTH-1:0] rise_q;
	logic                   await_q;
	logic                   pend_s1;
	logic [WIDTH_W-1:0]     width_s1;
	logic [TIMER_WIDTH-1:0] width_c;
	logic                   hit;

	assign hit = accept && flag;

	always_comb begin
		if (rise_q > now) begin
			width_c = period - rise_q + now;
		end else begin
			width_c = now - rise_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= '0;
			await_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (hit && !await_q) begin
				rise_q  <= now;
				await_q <= 1'b1;
			end else if (hit) begin
				await_q <= 1'b0;
			end
			if (hit && await_q) begin
				pend_s1 <= 1'b1;
			end else if (take) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && await_q) begin
			width_s1 <= WIDTH_W'(width_c);
		end
	end

	assign res.pend  = pend_s1;
	assign res.width = width_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/mpwc_merge.sv =====
`default_nettype none
module mpwc_merge #(
	parameter int CHANNELS = mpwc_pkg::CHANNELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  mpwc_pkg::lane_res_t                 res [CHANNELS],
	input  wire logic                           out_stall,
	output logic [CHANNELS-1:0]                 take,
	output logic                                drained,
	output logic                                out_valid,
	output logic [mpwc_pkg::CHAN_W-1:0]         channel,
	output logic [mpwc_pkg::WIDTH_W-1:0]        pulse_width,
	output logic                                last_result
);
	import mpwc_pkg::*;

	logic [CHANNELS-1:0] pend_vec;
	logic [CHANNELS-1:0] rest_vec;
	logic                found;
	logic [CHAN_W-1:0]   sel;
	logic [WIDTH_W-1:0]  sel_width;
	logic                load;
	logic                out_valid_q;
	logic [CHAN_W-1:0]   channel_q;
	logic [WIDTH_W-1:0]  width_q;
	logic                last_q;

	assign load = !out_valid_q || !out_stall;

	always_comb begin
		found     = 1'b0;
		sel       = '0;
		sel_width = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			pend_vec[i] = res[i].pend;
			if (res[i].pend && !found) begin
				found     = 1'b1;
				sel       = CHAN_W'(i);
				sel_width = res[i].width;
			end
		end
		for (int i = 0; i < CHANNELS; i++) begin
			take[i] = load && found && (sel == CHAN_W'(i));
		end
	end

	assign rest_vec = pend_vec & ~take;
	assign drained  = (rest_vec == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= found;
		end
	end

	always_ff @(posedge clk) begin
		if (load && found) begin
			channel_q <= sel;
			width_q   <= sel_width;
			last_q    <= drained;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel     = channel_q;
	assign pulse_width = width_q;
	assign last_result = last_q;

`ifndef ASSERT_OFF
	a_take_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(take))
		else $error("more than one lane drained in a cycle");

	a_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(take & ~pend_vec) == '0)
		else $error("lane drained without a pending result");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> pend_vec != '0)
		else $error("non-final result with nothing left to send");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && found |=> out_valid_q)
		else $error("pending result not moved to output");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/multichannel_pulse_width_capture_unit.sv =====
`default_nettype none
// Pulse-width capture for up to eight RC receiver pins.
// Input channel (in_valid/in_stall): edge_flags marks pins that saw an edge,
// timer_now is the timer count at that instant. A transfer happens when
// in_valid is high and in_stall is low.
// Each enabled pin alternates: a rise stores timer_now, a fall yields one
// result with the high time, corrected across a timer wrap by timer_period.
// Output channel (out_valid/out_stall): channel, pulse_width, last_result.
// Results of one item leave in ascending channel order; last_result marks
// the final one. Items with no falls give no result.
// The first result passes the lane result register, then the output
// register. The single output register drains one lane per cycle while
// out_stall is low. A new item is taken in the cycle the last pending
// result moves out. Receiver stall holds the output register; in_stall
// is high while any lane result stays pending after this cycle's take.
// Reset clears stored rise times, polarity bits and pending results and
// loads channel_mask = 0xFF, timer_period = 0xFFFF.
// Configuration: cfg_write with cfg_index 0 (channel_mask) or 1
// (timer_period); the user must write only while idle, the block does not enforce it.
module multichannel_pulse_width_capture_unit #(
	parameter int CHANNELS    = mpwc_pkg::CHANNELS_DEF,
	parameter int TIMER_WIDTH = mpwc_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [mpwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [mpwc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mpwc_pkg::MASK_W-1:0]       edge_flags,
	input  wire logic [15:0]                       timer_now,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mpwc_pkg::CHAN_W-1:0]            channel,
	output logic [mpwc_pkg::WIDTH_W-1:0]           pulse_width,
	output logic                                   last_result
);
	import mpwc_pkg::*;

	logic [MASK_W-1:0]      channel_mask_q;
	logic [PERIOD_W-1:0]    timer_period_q;
	logic                   accept;
	logic                   drained;
	logic [CHANNELS-1:0]    take;
	logic [TIMER_WIDTH-1:0] now_tw;
	logic [TIMER_WIDTH-1:0] period_tw;
	lane_res_t              res [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mask_q <= CHANNEL_MASK_RST;
			timer_period_q <= TIMER_PERIOD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CHANNEL_MASK: channel_mask_q <= cfg_data[MASK_W-1:0];
				REG_TIMER_PERIOD: timer_period_q <= cfg_data[PERIOD_W-1:0];
			endcase
		end
	end

	assign in_stall  = !drained;
	assign accept    = in_valid && drained;
	assign now_tw    = TIMER_WIDTH'(timer_now);
	assign period_tw = TIMER_WIDTH'(timer_period_q);

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		mpwc_lane #(
			.TIMER_WIDTH(TIMER_WIDTH)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.accept(accept),
			.flag  (edge_flags[i] && channel_mask_q[i]),
			.now   (now_tw),
			.period(period_tw),
			.take  (take[i]),
			.res   (res[i])
		);
	end

	mpwc_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.out_stall  (out_stall),
		.take       (take),
		.drained    (drained),
		.out_valid  (out_valid),
		.channel    (channel),
		.pulse_width(pulse_width),
		.last_result(last_result)
	);

endmodule
`default_nettype wire
